// File: sv/precision_weighted_error_update_assert.svh
// Assertion macros shared by the precision update block.
`ifndef PRECISION_WEIGHTED_ERROR_UPDATE_ASSERT_SVH
`define PRECISION_WEIGHTED_ERROR_UPDATE_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define PWE_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwe check failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define PWE_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwe check failed");

`endif

// File: sv/pwe_pkg.sv
`default_nettype none
package pwe_pkg;

    localparam int LP_LIMIT  = 20480;
    localparam int DIV_STEPS = 43;
    localparam int RECIP5    = 52429;

    localparam logic [23:0]        P_ONE       = 24'd65536;
    localparam logic [15:0]        RATE_RESET  = 16'd655;
    localparam logic [8:0]         BATCH_RESET = 9'd1;
    localparam logic [46:0]        T_MAX       = {47{1'b1}};
    localparam logic signed [47:0] E48_MAX     = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] E48_MIN     = {1'b1, {47{1'b0}}};

    localparam longint ONE_Q24  = 64'sd16777216;
    localparam longint HALF_Q24 = 64'sd8388608;
    localparam longint DIV1     = 64'sd16777216;
    localparam longint DIV2     = 64'sd33554432;
    localparam longint DIV3     = 64'sd50331648;
    localparam longint DIV4     = 64'sd67108864;
    localparam longint DIV5     = 64'sd83886080;

    typedef enum logic [0:0] {
        CFG_PRECISION_RATE = 1'b0,
        CFG_BATCH_SIZE     = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_MULT,
        ST_SUM,
        ST_ACC,
        ST_SCALE,
        ST_LOAD,
        ST_DIV,
        ST_LP,
        ST_IDX,
        ST_RECIP,
        ST_ROM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr;
        logic accept;
        logic addr;
        logic rd;
        logic mult;
        logic sum;
        logic acc;
        logic scale;
        logic load;
        logic step;
        logic lp;
        logic idx;
        logic recip;
        logic rom;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic last;
        logic div_done;
        logic out_free;
    } status_t;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v[49:47] != {3{v[49]}})
        begin
            r = v[49] ? E48_MIN : E48_MAX;
        end
        else
        begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic ovf48(input logic signed [49:0] v);
        return v[49:47] != {3{v[49]}};
    endfunction

    // exp(l/4096) in Q8.16: short series on l/131072, then square five times
    function automatic logic [23:0] exp_q16(input longint l);
        longint r;
        longint h;
        longint unsigned u;
        int k;
        r = l * 128;
        h = ONE_Q24;
        h = ONE_Q24 + (r * h) / DIV5;
        h = ONE_Q24 + (r * h) / DIV4;
        h = ONE_Q24 + (r * h) / DIV3;
        h = ONE_Q24 + (r * h) / DIV2;
        h = ONE_Q24 + (r * h) / DIV1;
        u = unsigned'(h);
        for (k = 0; k < 5; k++)
        begin
            u = (u * u + unsigned'(HALF_Q24)) >> 24;
        end
        u = (u + 64'd128) >> 8;
        if (u > 64'hFFFFFF)
        begin
            u = 64'hFFFFFF;
        end
        return u[23:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/pwe_if.sv
`default_nettype none
interface pwe_in_if;
    logic               valid;
    logic               ready;
    logic [9:0]         neuron_index;
    logic signed [31:0] error_value;
    logic               last_of_batch;

    modport source (output valid, neuron_index, error_value, last_of_batch, input ready);
    modport sink (input valid, neuron_index, error_value, last_of_batch, output ready);
endinterface

interface pwe_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] energy_term;
    logic [23:0]        precision_out;
    logic signed [15:0] log_precision_out;
    logic               updated;
    logic               saturated;

    modport source (output valid, energy_term, precision_out, log_precision_out, updated,
                    saturated, input ready);
    modport sink (input valid, energy_term, precision_out, log_precision_out, updated,
                  saturated, output ready);
endinterface
`default_nettype wire

// File: sv/pwe_ctrl.sv
`default_nettype none
module pwe_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pwe_pkg::status_t status,
    output pwe_pkg::cmd_t         cmd
);

    pwe_pkg::state_t state_reg;
    pwe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pwe_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            pwe_pkg::ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (status.clear_done)
                begin
                    state_next = pwe_pkg::ST_IDLE;
                end
            end
            pwe_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = pwe_pkg::ST_ADDR;
                end
            end
            pwe_pkg::ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = pwe_pkg::ST_READ;
            end
            pwe_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = pwe_pkg::ST_MULT;
            end
            pwe_pkg::ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = pwe_pkg::ST_SUM;
            end
            pwe_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = pwe_pkg::ST_ACC;
            end
            pwe_pkg::ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.last ? pwe_pkg::ST_SCALE : pwe_pkg::ST_DONE;
            end
            pwe_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = pwe_pkg::ST_LOAD;
            end
            pwe_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = pwe_pkg::ST_DIV;
            end
            pwe_pkg::ST_DIV:
            begin
                cmd.step = !status.div_done;
                if (status.div_done)
                begin
                    state_next = pwe_pkg::ST_LP;
                end
            end
            pwe_pkg::ST_LP:
            begin
                cmd.lp     = 1'b1;
                state_next = pwe_pkg::ST_IDX;
            end
            pwe_pkg::ST_IDX:
            begin
                cmd.idx    = 1'b1;
                state_next = pwe_pkg::ST_RECIP;
            end
            pwe_pkg::ST_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = pwe_pkg::ST_ROM;
            end
            pwe_pkg::ST_ROM:
            begin
                cmd.rom    = 1'b1;
                state_next = pwe_pkg::ST_DONE;
            end
            pwe_pkg::ST_DONE:
            begin
                // hold until the output register can take the result
                cmd.finish = status.out_free;
                if (status.out_free)
                begin
                    state_next = pwe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pwe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/pwe_dp.sv
`default_nettype none
module pwe_dp #(
    parameter int NEURONS           = 1024,
    parameter int BATCH_MAX         = 256,
    parameter int EXP_TABLE_ENTRIES = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire pwe_pkg::cfg_index_t cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic [9:0]          neuron_index,
    input  wire logic signed [31:0]  error_value,
    input  wire logic                last_of_batch,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [47:0]       energy_term,
    output logic [23:0]              precision_out,
    output logic signed [15:0]       log_precision_out,
    output logic                     updated,
    output logic                     saturated,
    input  wire pwe_pkg::cmd_t       cmd,
    output pwe_pkg::status_t         status
);

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int IW = $clog2(EXP_TABLE_ENTRIES);
    localparam int ESPAN = EXP_TABLE_ENTRIES - 1;
    localparam int MOD_M = ((1 << 20) + NEURONS - 1) / NEURONS;

    // configuration
    logic [15:0] rate_reg;
    logic [8:0]  batch_reg;
    logic [8:0]  bs_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= pwe_pkg::RATE_RESET;
            batch_reg <= pwe_pkg::BATCH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwe_pkg::CFG_PRECISION_RATE: rate_reg  <= cfg_data;
                pwe_pkg::CFG_BATCH_SIZE:     batch_reg <= cfg_data[8:0];
                default:                     rate_reg  <= rate_reg;
            endcase
        end
    end

    always_comb
    begin
        if (batch_reg == 9'd0)
        begin
            bs_eff = 9'd1;
        end
        else if (13'(batch_reg) > 13'(BATCH_MAX))
        begin
            bs_eff = 9'(BATCH_MAX);
        end
        else
        begin
            bs_eff = batch_reg;
        end
    end

    // transaction capture
    logic [9:0]         nidx_reg;
    logic signed [31:0] err_reg;
    logic               last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            nidx_reg <= neuron_index;
            err_reg  <= error_value;
            last_reg <= last_of_batch;
        end
    end

    // neuron index wrapped onto the store depth
    logic [AW-1:0] addr_w;
    logic [AW-1:0] addr_reg;

    generate
        if (NEURONS >= 1024)
        begin : g_nowrap
            assign addr_w = AW'(nidx_reg);
        end
        else
        begin : g_wrap
            logic [30:0] qprod;
            logic [10:0] quo;
            logic [10:0] rem;
            assign qprod = 31'(nidx_reg) * 31'(MOD_M);
            assign quo   = qprod[30:20];
            assign rem   = 11'(nidx_reg) - 11'(quo * 11'(NEURONS));
            assign addr_w = AW'(rem);
        end
    endgenerate

    // store: {precision, log precision}
    logic [39:0]   mem [NEURONS];
    logic [39:0]   rd_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [39:0]   mem_wd;
    logic [23:0]   rom_q_reg;
    logic signed [15:0] lp_new_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr && !status.clear_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign status.clear_done = (clr_cnt_reg == AW'(NEURONS - 1));

    always_comb
    begin
        mem_we = cmd.clr || (cmd.finish && last_reg);
        mem_wa = cmd.clr ? clr_cnt_reg : addr_reg;
        mem_wd = cmd.clr ? {pwe_pkg::P_ONE, 16'd0} : {rom_q_reg, lp_new_reg};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[addr_reg];
        end
    end

    logic [23:0]        p_rd;
    logic signed [15:0] lp_rd;
    assign p_rd  = rd_reg[39:16];
    assign lp_rd = rd_reg[15:0];

    // energy datapath
    logic [31:0] ae;
    logic [63:0] sq_full;
    logic [46:0] sq_reg;
    logic [23:0] pm;
    logic [47:0] pp_hi_reg;
    logic [46:0] pp_lo_reg;
    logic [70:0] total;
    logic [46:0] t_reg;
    logic        sat_t_reg;
    logic signed [49:0] e_full;
    logic signed [49:0] a_full;
    logic signed [47:0] acc_reg;
    logic signed [47:0] energy_reg;
    logic        sat_reg;

    assign ae      = err_reg[31] ? (~err_reg + 32'd1) : err_reg;
    assign sq_full = 64'(ae) * 64'(ae);
    assign pm      = (p_rd == 24'd0) ? 24'd1 : p_rd;
    assign total   = {pp_hi_reg, 23'd0} + 71'(pp_lo_reg);
    assign e_full  = $signed({3'b000, t_reg}) - ($signed({{34{lp_rd[15]}}, lp_rd}) <<< 3);
    assign a_full  = $signed({{2{acc_reg[47]}}, acc_reg}) + $signed({3'b000, t_reg})
                     - 50'sd32768;

    always_ff @(posedge clk)
    begin
        if (cmd.addr)
        begin
            addr_reg <= addr_w;
        end
        if (cmd.rd)
        begin
            sq_reg <= sq_full[62:16];
        end
        if (cmd.mult)
        begin
            pp_hi_reg <= 48'(sq_reg[46:23]) * 48'(pm);
            pp_lo_reg <= 47'(sq_reg[22:0]) * 47'(pm);
        end
        if (cmd.sum)
        begin
            sat_t_reg <= (total[70:64] != 7'd0);
            t_reg     <= (total[70:64] != 7'd0) ? pwe_pkg::T_MAX : total[63:17];
        end
        if (cmd.acc)
        begin
            energy_reg <= pwe_pkg::sat48(e_full);
            sat_reg    <= sat_t_reg || pwe_pkg::ovf48(e_full) || pwe_pkg::ovf48(a_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc)
        begin
            acc_reg <= pwe_pkg::sat48(a_full);
        end
        else if (cmd.finish && last_reg)
        begin
            acc_reg <= '0;
        end
    end

    assign status.last = last_reg;

    // mean gradient step: |acc| * rate / 2^20, then bit-serial divide by batch size
    logic [47:0] mag;
    logic [63:0] scale_full;
    logic [42:0] scale_reg;
    logic [42:0] quo_reg;
    logic [8:0]  rem_reg;
    logic [8:0]  div_reg;
    logic [5:0]  cnt_reg;
    logic [9:0]  rem_sh;
    logic        ge;

    assign mag        = acc_reg[47] ? 48'(-acc_reg) : 48'(acc_reg);
    assign scale_full = 64'(mag) * 64'(rate_reg);
    assign rem_sh     = {rem_reg, quo_reg[42]};
    assign ge         = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= 6'(pwe_pkg::DIV_STEPS);
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            scale_reg <= scale_full[62:20];
        end
        if (cmd.load)
        begin
            quo_reg <= scale_reg;
            rem_reg <= '0;
            div_reg <= bs_eff;
        end
        else if (cmd.step)
        begin
            rem_reg <= ge ? 9'(rem_sh - {1'b0, div_reg}) : rem_sh[8:0];
            quo_reg <= {quo_reg[41:0], ge};
        end
    end

    assign status.div_done = (cnt_reg == 6'd0);

    // log precision update and table index
    logic signed [44:0] lp_wide;
    logic signed [15:0] lp_clamp;
    logic [16:0]        off_w;
    logic [29:0]        x_reg;
    logic [32:0]        y_prod;
    logic [14:0]        idx_raw;
    logic [IW-1:0]      idx_reg;

    assign lp_wide = acc_reg[47]
                     ? ($signed({{29{lp_rd[15]}}, lp_rd}) + $signed({2'b00, quo_reg}))
                     : ($signed({{29{lp_rd[15]}}, lp_rd}) - $signed({2'b00, quo_reg}));

    always_comb
    begin
        if (lp_wide > 45'sd20480)
        begin
            lp_clamp = 16'sd20480;
        end
        else if (lp_wide < -45'sd20480)
        begin
            lp_clamp = -16'sd20480;
        end
        else
        begin
            lp_clamp = lp_wide[15:0];
        end
    end

    assign off_w   = 17'($signed({lp_new_reg[15], lp_new_reg}) + 17'sd20480);
    assign y_prod  = 33'(x_reg[29:13]) * 33'(pwe_pkg::RECIP5);
    assign idx_raw = y_prod[32:18];

    always_ff @(posedge clk)
    begin
        if (cmd.lp)
        begin
            lp_new_reg <= lp_clamp;
        end
        if (cmd.idx)
        begin
            x_reg <= 30'(off_w[15:0]) * 30'(ESPAN) + 30'(pwe_pkg::LP_LIMIT);
        end
        if (cmd.recip)
        begin
            idx_reg <= (15'(idx_raw) > 15'(ESPAN)) ? IW'(ESPAN) : IW'(idx_raw);
        end
    end

    // exp table, one entry per grid point of log precision
    logic [23:0] exp_rom [EXP_TABLE_ENTRIES];

    generate
        for (genvar gi = 0; gi < EXP_TABLE_ENTRIES; gi++)
        begin : g_rom
            localparam int LI = -pwe_pkg::LP_LIMIT
                                + (gi * 2 * pwe_pkg::LP_LIMIT + ESPAN / 2) / ESPAN;
            localparam logic [23:0] EV = pwe_pkg::exp_q16(longint'(LI));
            assign exp_rom[gi] = EV;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.rom)
        begin
            rom_q_reg <= exp_rom[idx_reg];
        end
    end

    // output register
    logic               out_valid_reg;
    logic signed [47:0] o_energy_reg;
    logic [23:0]        o_p_reg;
    logic signed [15:0] o_lp_reg;
    logic               o_upd_reg;
    logic               o_sat_reg;

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            o_energy_reg <= energy_reg;
            o_p_reg      <= last_reg ? rom_q_reg : p_rd;
            o_lp_reg     <= last_reg ? lp_new_reg : lp_rd;
            o_upd_reg    <= last_reg;
            o_sat_reg    <= sat_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign energy_term       = o_energy_reg;
    assign precision_out     = o_p_reg;
    assign log_precision_out = o_lp_reg;
    assign updated           = o_upd_reg;
    assign saturated         = o_sat_reg;

endmodule
`default_nettype wire

// File: sv/precision_weighted_error_update.sv
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    neuron_index, error_value, last_of_batch
// out_ch   out  valid/ready    energy_term, precision_out, log_precision_out, updated, saturated
// cfg      in   cfg_we         cfg_index, cfg_data
//
// One transaction at a time: in_ch.ready stays low from accept until the result is
// loaded; an item that closes a batch also runs the 43-step bit-serial divide.
// After reset the stores are swept to 1.0 / 0 while in_ch.ready is low.
// A result waits in the output register while the next transaction is accepted.
`default_nettype none
module precision_weighted_error_update #(
    parameter int NEURONS           = 1024,
    parameter int BATCH_MAX         = 256,
    parameter int EXP_TABLE_ENTRIES = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire pwe_pkg::cfg_index_t cfg_index,
    input  wire logic [15:0]         cfg_data,
    pwe_in_if.sink                   in_ch,
    pwe_out_if.source                out_ch
);

    pwe_pkg::cmd_t    cmd;
    pwe_pkg::status_t status;

    pwe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pwe_dp #(
        .NEURONS           (NEURONS),
        .BATCH_MAX         (BATCH_MAX),
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .neuron_index      (in_ch.neuron_index),
        .error_value       (in_ch.error_value),
        .last_of_batch     (in_ch.last_of_batch),
        .out_valid         (out_ch.valid),
        .out_ready         (out_ch.ready),
        .energy_term       (out_ch.energy_term),
        .precision_out     (out_ch.precision_out),
        .log_precision_out (out_ch.log_precision_out),
        .updated           (out_ch.updated),
        .saturated         (out_ch.saturated),
        .cmd               (cmd),
        .status            (status)
    );

`include "precision_weighted_error_update_assert.svh"

    `PWE_ASSERT_NXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready)
    `PWE_ASSERT_NXT(a_finish_shows, cmd.finish, out_ch.valid)
    `PWE_ASSERT_IMP(a_lp_range, out_ch.valid && out_ch.updated,
                    (out_ch.log_precision_out <= 16'sd20480)
                    && (out_ch.log_precision_out >= -16'sd20480))

endmodule
`default_nettype wire
